// ===== src/pls_pkg.sv =====
package pls_pkg;

  localparam int CAPACITY_DEF = 128;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_INSERT = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_TAIL,
    S_PUT,
    S_RDWAIT,
    S_RESP
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic shift;
    logic tail;
    logic put;
    logic cap;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_ins;
    logic is_del;
    logic is_wr;
    logic is_rd;
    logic ok;
    logic no_shift;
    logic last;
  } dp_sts_t;

endpackage

// ===== src/pls_ram.sv =====
module pls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = pls_pkg::CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/pls_ctrl.sv =====
module pls_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  pls_pkg::dp_sts_t    sts_i,
  output pls_pkg::ctrl_cmd_t  cmd_o,
  output logic                busy_o,
  output logic                done_o
);

  pls_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pls_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pls_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = pls_pkg::S_EXEC;
        end
      end
      pls_pkg::S_EXEC: begin
        if (!sts_i.ok) begin
          state_d = pls_pkg::S_RESP;
        end else if (sts_i.is_ins) begin
          state_d = sts_i.no_shift ? pls_pkg::S_PUT : pls_pkg::S_SHIFT;
        end else if (sts_i.is_del) begin
          state_d = sts_i.no_shift ? pls_pkg::S_RESP : pls_pkg::S_SHIFT;
        end else if (sts_i.is_wr) begin
          state_d = pls_pkg::S_PUT;
        end else if (sts_i.is_rd) begin
          state_d = pls_pkg::S_RDWAIT;
        end else begin
          state_d = pls_pkg::S_RESP;
        end
      end
      pls_pkg::S_SHIFT: begin
        if (sts_i.last) begin
          state_d = pls_pkg::S_TAIL;
        end
      end
      pls_pkg::S_TAIL: begin
        state_d = sts_i.is_ins ? pls_pkg::S_PUT : pls_pkg::S_RESP;
      end
      pls_pkg::S_PUT:    state_d = pls_pkg::S_RESP;
      pls_pkg::S_RDWAIT: state_d = pls_pkg::S_RESP;
      pls_pkg::S_RESP:   state_d = pls_pkg::S_IDLE;
      default:           state_d = pls_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    case (state_q)
      pls_pkg::S_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      pls_pkg::S_EXEC:   cmd_o.exec  = 1'b1;
      pls_pkg::S_SHIFT:  cmd_o.shift = 1'b1;
      pls_pkg::S_TAIL:   cmd_o.tail  = 1'b1;
      pls_pkg::S_PUT:    cmd_o.put   = 1'b1;
      pls_pkg::S_RDWAIT: cmd_o.cap   = 1'b1;
      pls_pkg::S_RESP:   done_o      = 1'b1;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== src/pls_dp.sv =====
module pls_dp #(
  parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pls_pkg::ctrl_cmd_t  cmd_i,
  output pls_pkg::dp_sts_t    sts_o,
  input  logic [2:0]          cmd_in_i,
  input  logic [7:0]          position_i,
  input  logic signed [31:0]  value_i,
  output logic [1:0]          status_o,
  output logic signed [31:0]  read_data_o,
  output logic [7:0]          entry_count_o
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > 8) ? CW : 8) + 1;

  logic [2:0]         cmd_q;
  logic [7:0]         pos_q;
  logic signed [31:0] val_q;
  logic [AW-1:0]      ptr_q, wptr_q;
  logic               pend_q;
  logic [CW-1:0]      count_q;
  logic [1:0]         status_q;
  logic signed [31:0] rdata_q;

  logic [CMPW-1:0] pos_c, cnt_c, pos_m1, cnt_m1;
  logic [AW-1:0]   pos_addr, cnt_addr_m1;
  logic [1:0]      code;
  logic            is_ins, is_del, is_wr, is_rd;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [31:0]     ram_wdata, ram_rdata;

  assign pos_c       = CMPW'(pos_q);
  assign cnt_c       = CMPW'(count_q);
  assign pos_m1      = pos_c - CMPW'(1);
  assign cnt_m1      = cnt_c - CMPW'(1);
  assign pos_addr    = pos_m1[AW-1:0];
  assign cnt_addr_m1 = cnt_m1[AW-1:0];

  assign is_ins = (cmd_q == pls_pkg::CMD_INSERT);
  assign is_del = (cmd_q == pls_pkg::CMD_DELETE);
  assign is_wr  = (cmd_q == pls_pkg::CMD_WRITE);
  assign is_rd  = (cmd_q == pls_pkg::CMD_READ);

  // full before position for insert, empty before position for write, delete and read
  always_comb begin
    code = pls_pkg::ST_OK;
    case (cmd_q)
      pls_pkg::CMD_INSERT: begin
        if (cnt_c >= CMPW'(CAPACITY)) begin
          code = pls_pkg::ST_FULL;
        end else if (pos_c == '0 || pos_c > cnt_c + CMPW'(1)) begin
          code = pls_pkg::ST_BADPOS;
        end
      end
      pls_pkg::CMD_WRITE, pls_pkg::CMD_DELETE, pls_pkg::CMD_READ: begin
        if (count_q == '0) begin
          code = pls_pkg::ST_EMPTY;
        end else if (pos_c == '0 || pos_c > cnt_c) begin
          code = pls_pkg::ST_BADPOS;
        end
      end
      default: code = pls_pkg::ST_OK;
    endcase
  end

  always_comb begin
    sts_o.is_ins   = is_ins;
    sts_o.is_del   = is_del;
    sts_o.is_wr    = is_wr;
    sts_o.is_rd    = is_rd;
    sts_o.ok       = (code == pls_pkg::ST_OK);
    sts_o.no_shift = is_ins ? (pos_c == cnt_c + CMPW'(1)) : (pos_c == cnt_c);
    sts_o.last     = is_ins ? (ptr_q == pos_addr) : (ptr_q == cnt_addr_m1);
  end

  // shift moves one entry per cycle: read the source, write it in the following cycle
  assign ram_re    = cmd_i.exec | cmd_i.shift;
  assign ram_raddr = cmd_i.shift ? ptr_q : pos_addr;
  assign ram_we    = (cmd_i.shift & pend_q) | cmd_i.tail | cmd_i.put;
  assign ram_waddr = cmd_i.put ? pos_addr : wptr_q;
  assign ram_wdata = cmd_i.put ? val_q : ram_rdata;

  pls_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= cmd_in_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
    if (cmd_i.exec) begin
      ptr_q <= is_ins ? cnt_addr_m1 : pos_c[AW-1:0];
    end else if (cmd_i.shift) begin
      ptr_q  <= is_ins ? ptr_q - AW'(1) : ptr_q + AW'(1);
      wptr_q <= is_ins ? ptr_q + AW'(1) : ptr_q - AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 1'b0;
      count_q  <= '0;
      status_q <= pls_pkg::ST_OK;
      rdata_q  <= '0;
    end else begin
      if (cmd_i.exec) begin
        pend_q   <= 1'b0;
        status_q <= code;
        rdata_q  <= '0;
        if (cmd_q == pls_pkg::CMD_CLEAR) begin
          count_q <= '0;
        end else if (is_del && sts_o.ok && sts_o.no_shift) begin
          count_q <= count_q - CW'(1);
        end
      end
      if (cmd_i.shift) begin
        pend_q <= 1'b1;
      end
      if (cmd_i.tail && is_del) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.put && is_ins) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.cap) begin
        rdata_q <= ram_rdata;
      end
    end
  end

  assign status_o      = status_q;
  assign read_data_o   = rdata_q;
  assign entry_count_o = cnt_c[7:0];

endmodule

// ===== src/positional_list_store.sv =====
// an accepted start leads to EXEC and ends in RESP, which raises done_o: clear, unused
// codes, errors and a tail delete go there directly; overwrite and append pass PUT, read
// passes RDWAIT, an insert that moves entries passes SHIFT, TAIL and PUT, and such a delete
// SHIFT and TAIL; busy_o drops the cycle after done_o; the shift moves one entry per cycle.
// reset clears the count and the controller; entry storage has no reset and no clear pass.
// done_o is high for a single cycle and marks the results; the receiver cannot stall.
module positional_list_store #(
  parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         cmd_i,
  input  logic [7:0]         position_i,
  input  logic signed [31:0] value_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] read_data_o,
  output logic [7:0]         entry_count_o
);

  pls_pkg::ctrl_cmd_t ctrl_cmd;
  pls_pkg::dp_sts_t   dp_sts;

  pls_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (dp_sts),
    .cmd_o   (ctrl_cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  pls_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (ctrl_cmd),
    .sts_o         (dp_sts),
    .cmd_in_i      (cmd_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .status_o      (status_o),
    .read_data_o   (read_data_o),
    .entry_count_o (entry_count_o)
  );

endmodule

// ===== src/pls_checker.sv =====
module pls_checker #(
  parameter int CAPACITY = pls_pkg::CAPACITY_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic [1:0]         status_o,
  input logic signed [31:0] read_data_o,
  input logic [7:0]         entry_count_o
);

  // an accepted transaction makes the block busy
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy_o not raised after accepted transaction");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done_o held longer than one cycle");

  // ready again right after the result
  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("busy_o still high after result");

  a_err_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != pls_pkg::ST_OK |-> read_data_o == '0)
    else $error("read_data_o nonzero on failed transaction");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == pls_pkg::ST_FULL |-> entry_count_o == 8'(CAPACITY))
    else $error("full status with count below capacity");

endmodule

bind positional_list_store pls_checker #(
  .CAPACITY (CAPACITY)
) u_pls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .status_o      (status_o),
  .read_data_o   (read_data_o),
  .entry_count_o (entry_count_o)
);

// ===== tb/tb_positional_list_store.sv =====
module tb_positional_list_store;
  import pls_pkg::*;

  localparam int LIST_DEPTH     = CAPACITY_DEF;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int SEGMENT_LEN    = 50;
  localparam int CALM_TAIL      = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 100;

  // command codes the block ignores
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_e;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] read_data;
    logic [7:0]         entry_count;
  } list_result_t;

  class list_scoreboard;
    logic signed [31:0] words [LIST_DEPTH];
    int                 length = 0;
    list_result_t       pending_q [$];
    int                 errors = 0;
    int                 commands = 0;
    int                 results = 0;
    int                 peak = 0;
    int                 status_hits [4] = '{default: 0};

    function int pending();
      return pending_q.size();
    endfunction

    // apply one accepted transaction to the shadow list and queue its result
    function void note_command(logic [2:0] cmd, logic [7:0] pos, logic signed [31:0] val);
      list_result_t res;
      int p;
      p = int'(pos);
      res.status = ST_OK;
      res.read_data = '0;
      case (cmd)
        CMD_CLEAR: length = 0;
        CMD_INSERT: begin
          if (length >= LIST_DEPTH) res.status = ST_FULL;
          else if (p < 1 || p > length + 1) res.status = ST_BADPOS;
          else begin
            for (int i = length; i > p - 1; i--) words[i] = words[i - 1];
            words[p - 1] = val;
            length++;
          end
        end
        CMD_WRITE, CMD_DELETE, CMD_READ: begin
          if (length == 0) res.status = ST_EMPTY;
          else if (p < 1 || p > length) res.status = ST_BADPOS;
          else if (cmd == CMD_WRITE) words[p - 1] = val;
          else if (cmd == CMD_DELETE) begin
            for (int i = p - 1; i + 1 < length; i++) words[i] = words[i + 1];
            length--;
          end else res.read_data = words[p - 1];
        end
        default: ;
      endcase
      res.entry_count = 8'(length);
      status_hits[res.status]++;
      if (length > peak) peak = length;
      commands++;
      pending_q.push_back(res);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%0t: mismatch: %s", $time, msg);
    endtask

    task check_result(logic [1:0] st, logic signed [31:0] rd, logic [7:0] cnt);
      list_result_t want;
      results++;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result %0d with no command pending (status %0d count %0d)",
                                  results, st, cnt));
        return;
      end
      want = pending_q.pop_front();
      if (st !== want.status)
        report_mismatch($sformatf("result %0d status %0d, want %0d", results, st, want.status));
      if (rd !== want.read_data)
        report_mismatch($sformatf("result %0d read_data %0d, want %0d",
                                  results, rd, want.read_data));
      if (cnt !== want.entry_count)
        report_mismatch($sformatf("result %0d entry_count %0d, want %0d",
                                  results, cnt, want.entry_count));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic [2:0]         cmd_i = '0;
  logic [7:0]         position_i = '0;
  logic signed [31:0] value_i = '0;
  logic               busy_o;
  logic               done_o;
  logic [1:0]         status_o;
  logic signed [31:0] read_data_o;
  logic [7:0]         entry_count_o;

  list_scoreboard sb;
  bit             gaps_on = 1'b0;

  positional_list_store uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .cmd_i        (cmd_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_data_o  (read_data_o),
    .entry_count_o(entry_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(status_o, read_data_o, entry_count_o);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || done_o) quiet = 0;
      else quiet++;
    end
    $display("no transaction for %0d cycles, giving up", WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // hold the command until the block takes it
  task automatic issue(logic [2:0] cmd, logic [7:0] pos, logic signed [31:0] val);
    start_i    <= 1'b1;
    cmd_i      <= cmd;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.note_command(cmd, pos, val);
  endtask

  task automatic hold(int n);
    start_i    <= 1'b0;
    cmd_i      <= 3'($urandom);
    position_i <= 8'($urandom);
    value_i    <= $urandom;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) hold($urandom_range(1, 8));
  endtask

  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic random_command(mix_e mix);
    int                 r;
    int                 w_ins;
    int                 w_wr;
    int                 w_del;
    int                 len;
    logic [2:0]         cmd;
    logic [7:0]         pos;
    logic signed [31:0] val;
    len = sb.length;
    case (mix)
      MIX_FILL:  begin w_ins = 60; w_wr = 10; w_del = 10; end
      MIX_DRAIN: begin w_ins = 10; w_wr = 10; w_del = 60; end
      default:   begin w_ins = 30; w_wr = 20; w_del = 25; end
    endcase
    r = $urandom_range(0, 99);
    if (mix == MIX_BALANCED && r < 1) cmd = CMD_CLEAR;
    else if (r < 3) cmd = 3'($urandom_range(int'(CMD_SPARE_LAST), int'(CMD_SPARE_FIRST)));
    else begin
      r = $urandom_range(0, 99);
      if (r < w_ins) cmd = CMD_INSERT;
      else if (r < w_ins + w_wr) cmd = CMD_WRITE;
      else if (r < w_ins + w_wr + w_del) cmd = CMD_DELETE;
      else cmd = CMD_READ;
    end
    if ($urandom_range(0, 99) < 12 || (len == 0 && cmd != CMD_INSERT))
      pos = 8'($urandom_range(0, 255));
    else if (cmd == CMD_INSERT) pos = 8'($urandom_range(1, len + 1));
    else pos = 8'($urandom_range(1, len));
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0:       val = 32'sh7FFF_FFFF;
        1:       val = 32'sh8000_0000;
        2:       val = '0;
        default: val = '1;
      endcase
    end else val = $urandom;
    maybe_gap();
    issue(cmd, pos, val);
  endtask

  initial begin : stimulus
    mix_e mix;
    int   r;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: the empty check wins over the position check
    issue(CMD_READ, 8'd0, '0);
    issue(CMD_DELETE, 8'd255, '0);
    issue(CMD_WRITE, 8'd1, 32'sh1234_5678);
    issue(CMD_CLEAR, 8'd0, '0);
    issue(CMD_INSERT, 8'd0, 32'sd5);
    issue(CMD_INSERT, 8'd2, 32'sd5);
    issue(CMD_INSERT, 8'd1, 32'sh7FFF_FFFF);
    issue(CMD_INSERT, 8'd1, 32'sh8000_0000);
    issue(CMD_INSERT, 8'd3, -32'sd1);
    issue(CMD_INSERT, 8'd2, '0);
    issue(CMD_INSERT, 8'd255, 32'sd7);
    drain();
    for (int p = 1; p <= 5; p++) issue(CMD_READ, 8'(p), '0);
    issue(CMD_WRITE, 8'd2, 32'sh5555_5555);
    issue(CMD_WRITE, 8'd5, 32'shAAAA_AAAA);
    issue(CMD_DELETE, 8'd1, '0);
    issue(CMD_DELETE, 8'd3, '0);
    issue(CMD_DELETE, 8'd0, '0);
    issue(CMD_SPARE_FIRST, 8'hFF, 32'sh7FFF_FFFF);
    issue(CMD_SPARE_FIRST + 3'd1, 8'd1, -32'sd1);
    issue(CMD_SPARE_LAST, 8'd2, 32'sh8000_0000);
    issue(CMD_READ, 8'd2, '0);
    issue(CMD_CLEAR, 8'd0, '0);

    // fill to capacity, then hit the full list and the longest shifts
    gaps_on = 1'b1;
    for (int n = 0; n < LIST_DEPTH; n++) begin
      maybe_gap();
      issue(CMD_INSERT, 8'($urandom_range(1, sb.length + 1)), $urandom);
    end
    issue(CMD_INSERT, 8'd0, $urandom);
    issue(CMD_INSERT, 8'(LIST_DEPTH + 1), $urandom);
    issue(CMD_READ, 8'(LIST_DEPTH), '0);
    issue(CMD_READ, 8'(LIST_DEPTH + 1), '0);
    issue(CMD_DELETE, 8'd1, '0);
    issue(CMD_INSERT, 8'd1, $urandom);
    issue(CMD_READ, 8'd1, '0);
    issue(CMD_READ, 8'd2, '0);
    drain();

    for (int seg = 0; seg < RANDOM_ITEMS / SEGMENT_LEN; seg++) begin
      r = $urandom_range(0, 9);
      mix = (r < 4) ? MIX_FILL : (r < 6) ? MIX_DRAIN : MIX_BALANCED;
      gaps_on = (seg * SEGMENT_LEN < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < SEGMENT_LEN; k++) random_command(mix);
      if (gaps_on && $urandom_range(0, 3) == 0) drain();
    end

    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    // catch any stray result after the last one
    repeat (LIST_DEPTH + 8) @(posedge clk_i);
    if (sb.pending() != 0) sb.report_mismatch($sformatf("%0d results never came", sb.pending()));

    $display("covered %0d commands, %0d results checked, longest list %0d of %0d entries",
             sb.commands, sb.results, sb.peak, LIST_DEPTH);
    $display("status seen: ok %0d, full %0d, empty %0d, bad position %0d",
             sb.status_hits[ST_OK], sb.status_hits[ST_FULL], sb.status_hits[ST_EMPTY],
             sb.status_hits[ST_BADPOS]);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/pls_pkg.sv
src/pls_ram.sv
src/pls_ctrl.sv
src/pls_dp.sv
src/positional_list_store.sv
src/pls_checker.sv
tb/tb_positional_list_store.sv
